// ----- rtl/core/gdd_pkg.sv -----
// Shared widths, constants, tables and types for the Gregorian date difference block.
package gdd_pkg;

    localparam int DAY_W         = 5;
    localparam int MONTH_W       = 4;
    localparam int YEAR_W        = 14;
    localparam int DIFF_W        = 23;
    localparam int MAX_YEAR_DEF  = 9999;

    // floor(y / 100) == (y * RECIP100) >> RECIP100_SH for every 14-bit y.
    localparam int RECIP100      = 5243;
    localparam int RECIP100_W    = 13;
    localparam int RECIP100_SH   = 19;
    localparam int PROD100_W     = YEAR_W + RECIP100_W;
    localparam int Q100_W        = PROD100_W - RECIP100_SH;

    localparam int MSTART_W      = 9;
    localparam int SMALL_W       = YEAR_W - 2;

    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = DAY_W'(29);

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    // Length of a month in a common year; zero for codes that name no month.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
            4'd2:                                       len = DAY_W'(28);
            default:                                    len = '0;
        endcase
        return len;
    endfunction

    // Days of a common year before the first day of a month.
    function automatic logic [MSTART_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [MSTART_W-1:0] s;
        unique case (m)
            4'd2:    s = MSTART_W'(31);
            4'd3:    s = MSTART_W'(59);
            4'd4:    s = MSTART_W'(90);
            4'd5:    s = MSTART_W'(120);
            4'd6:    s = MSTART_W'(151);
            4'd7:    s = MSTART_W'(181);
            4'd8:    s = MSTART_W'(212);
            4'd9:    s = MSTART_W'(243);
            4'd10:   s = MSTART_W'(273);
            4'd11:   s = MSTART_W'(304);
            4'd12:   s = MSTART_W'(334);
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/core/gregorian_date_difference.sv -----
// Top level: two day-number pipelines, the subtraction stage and the output handshake.
// Pipeline: four register stages, the last of which drives the m_ ports.
// Throughput: one item per cycle while m_ready is high; each stage advances on its own,
// so bubbles close up during an output stall; the input is ready when any stage can move.
// Reset (aresetn low, synchronous) clears only the stage valid bits; no item survives it.
// Datapath registers hold no reset value and are loaded as items pass.
module gregorian_date_difference import gdd_pkg::*; #(
    parameter int MAX_YEAR = MAX_YEAR_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [DAY_W-1:0]         s_first_day,
    input  logic [MONTH_W-1:0]       s_first_month,
    input  logic [YEAR_W-1:0]        s_first_year,
    input  logic [DAY_W-1:0]         s_second_day,
    input  logic [MONTH_W-1:0]       s_second_month,
    input  logic [YEAR_W-1:0]        s_second_year,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_first_valid,
    output logic                     m_second_valid,
    output logic signed [DIFF_W-1:0] m_day_difference,
    output logic                     m_second_earlier
);

    localparam int DN_W  = $clog2(MAX_YEAR * 366 + 1);
    localparam int EXT_W = (DN_W + 1 > DIFF_W) ? DN_W + 1 : DIFF_W;

    logic      v1_reg, v2_reg, v3_reg, v4_reg;
    logic      en1, en2, en3, en4;
    stage_en_t en;

    always_comb begin
        en4  = !v4_reg || m_ready;
        en3  = !v3_reg || en4;
        en2  = !v2_reg || en3;
        en1  = !v1_reg || en2;
        en.s1 = en1;
        en.s2 = en2;
        en.s3 = en3;
    end

    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    logic [DN_W-1:0] dn_first, dn_second;
    logic            ok_first, ok_second;

    gdd_day_number #(.MAX_YEAR(MAX_YEAR), .DN_W(DN_W)) u_first (
        .aclk    (aclk),
        .en      (en),
        .day     (s_first_day),
        .month   (s_first_month),
        .year    (s_first_year),
        .day_num (dn_first),
        .date_ok (ok_first)
    );

    gdd_day_number #(.MAX_YEAR(MAX_YEAR), .DN_W(DN_W)) u_second (
        .aclk    (aclk),
        .en      (en),
        .day     (s_second_day),
        .month   (s_second_month),
        .year    (s_second_year),
        .day_num (dn_second),
        .date_ok (ok_second)
    );

    // Output stage: the difference is forced to zero unless both dates are valid.
    logic                     first_valid_reg, second_valid_reg, earlier_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [DN_W:0]     diff_full;
    logic signed [EXT_W-1:0]  diff_ext;
    logic                     both_ok;

    always_comb begin
        both_ok   = ok_first && ok_second;
        diff_full = signed'({1'b0, dn_second}) - signed'({1'b0, dn_first});
        diff_ext  = EXT_W'(diff_full);
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            first_valid_reg  <= ok_first;
            second_valid_reg <= ok_second;
            diff_reg         <= both_ok ? diff_ext[DIFF_W-1:0] : '0;
            earlier_reg      <= both_ok && (dn_second < dn_first);
        end
    end

    assign m_valid          = v4_reg;
    assign m_first_valid    = first_valid_reg;
    assign m_second_valid   = second_valid_reg;
    assign m_day_difference = diff_reg;
    assign m_second_earlier = earlier_reg;

endmodule

// ----- rtl/core/gdd_day_number.sv -----
// Three-stage pipeline that checks one date and converts it to a day number.
module gdd_day_number import gdd_pkg::*; #(
    parameter int MAX_YEAR = MAX_YEAR_DEF,
    parameter int DN_W     = $clog2(MAX_YEAR * 366 + 1)
) (
    input  logic               aclk,
    input  stage_en_t          en,
    input  logic [DAY_W-1:0]   day,
    input  logic [MONTH_W-1:0] month,
    input  logic [YEAR_W-1:0]  year,
    output logic [DN_W-1:0]    day_num,
    output logic               date_ok
);

    localparam int YCMP_W = 17;

    // Stage 1: range checks and the two divisions by 100.
    logic [YEAR_W-1:0]    year_reg,   pm1_reg;
    logic [Q100_W-1:0]    qy_reg,     qp_reg;
    logic [MONTH_W-1:0]   m1_reg;
    logic [DAY_W-1:0]     d1_reg;
    logic                 range_ok1_reg, len_ok1_reg, feb29_1_reg;

    logic [YEAR_W-1:0]    pm1_next;
    logic [PROD100_W-1:0] prod_y, prod_p;
    logic                 range_ok_next, len_ok_next, feb29_next;

    always_comb begin
        pm1_next      = year - YEAR_W'(1);
        prod_y        = PROD100_W'(year) * PROD100_W'(RECIP100);
        prod_p        = PROD100_W'(pm1_next) * PROD100_W'(RECIP100);
        range_ok_next = (month >= MONTH_JAN) && (month <= MONTH_DEC) &&
                        (year != '0) && (YCMP_W'(year) <= YCMP_W'(MAX_YEAR)) &&
                        (day != '0);
        len_ok_next   = day <= month_len(month);
        feb29_next    = (month == MONTH_FEB) && (day == FEB_LEAP_LEN);
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            year_reg      <= year;
            pm1_reg       <= pm1_next;
            qy_reg        <= prod_y[PROD100_W-1:RECIP100_SH];
            qp_reg        <= prod_p[PROD100_W-1:RECIP100_SH];
            m1_reg        <= month;
            d1_reg        <= day;
            range_ok1_reg <= range_ok_next;
            len_ok1_reg   <= len_ok_next;
            feb29_1_reg   <= feb29_next;
        end
    end

    // Stage 2: leap year test and the whole-year part of the day number.
    logic [DN_W-1:0]      base_reg;
    logic [SMALL_W-1:0]   small_reg;
    logic                 leap_reg;
    logic [MONTH_W-1:0]   m2_reg;
    logic [DAY_W-1:0]     d2_reg;
    logic                 range_ok2_reg, len_ok2_reg, feb29_2_reg;

    logic                 div100, leap_next;
    logic [SMALL_W-1:0]   small_next;

    always_comb begin
        div100     = year_reg == YEAR_W'(qy_reg) * YEAR_W'(100);
        leap_next  = ((year_reg[1:0] == 2'b00) && !div100) ||
                     (div100 && (qy_reg[1:0] == 2'b00));
        small_next = pm1_reg[YEAR_W-1:2] - SMALL_W'(qp_reg) + SMALL_W'(qp_reg >> 2);
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            base_reg      <= DN_W'(365 * pm1_reg);
            small_reg     <= small_next;
            leap_reg      <= leap_next;
            m2_reg        <= m1_reg;
            d2_reg        <= d1_reg;
            range_ok2_reg <= range_ok1_reg;
            len_ok2_reg   <= len_ok1_reg;
            feb29_2_reg   <= feb29_1_reg;
        end
    end

    // Stage 3: add the month and day parts and settle validity.
    logic [DN_W-1:0] dn_reg;
    logic            ok_reg;
    logic            leap_adj;

    assign leap_adj = leap_reg && (m2_reg > MONTH_FEB);

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            dn_reg <= base_reg + DN_W'(small_reg) + DN_W'(month_start(m2_reg)) +
                      DN_W'(leap_adj) + DN_W'(d2_reg) - DN_W'(1);
            ok_reg <= range_ok2_reg && (len_ok2_reg || (feb29_2_reg && leap_reg));
        end
    end

    assign day_num = dn_reg;
    assign date_ok = ok_reg;

endmodule
